FILE: rtl/core/scff_pkg.sv
// Shared types, codes and constants of the sensor chain frame forwarder.
// No dependencies; every other file of the block but scff_ram refers to this package.
package scff_pkg;

    localparam int OBS_ENTRIES_DEF    = 64;
    localparam int INSTANCE_LIMIT_DEF = 64;
    localparam int FRAME_BYTES_DEF    = 5;
    localparam int FRAME_BYTES_MAX    = 8;
    localparam int FRAME_IDX_W        = $clog2(FRAME_BYTES_MAX);
    localparam int ADDR_W             = 12;
    localparam int QUEUE_DEPTH        = 2;
    localparam int CFG_IDX_W          = 2;

    localparam logic [7:0] START_CODE_RST   = 8'd128;
    localparam logic [7:0] STOP_CODE_RST    = 8'd64;
    localparam logic [3:0] SILENT_TICKS_RST = 4'd3;

    localparam logic [1:0] IN_BYTE    = 2'd0;
    localparam logic [1:0] IN_TICK    = 2'd1;
    localparam logic [1:0] IN_REQUEST = 2'd2;

    localparam logic [1:0] OUT_BYTE   = 2'd0;
    localparam logic [1:0] OUT_SLOT   = 2'd1;
    localparam logic [1:0] OUT_ANSWER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENT_TICKS = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        rx_byte;
        logic [ADDR_W-1:0] obs_address;
    } in_item_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [7:0] next_instance;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] stop_code;
        logic [3:0] silent_ticks;
    } cfg_t;

    typedef enum logic [2:0] {
        CMD_FRAME       = 3'd0,
        CMD_FRAME_START = 3'd1,
        CMD_SLOT_STOP   = 3'd2,
        CMD_TICK        = 3'd3,
        CMD_ANSWER      = 3'd4
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                         op;
        logic [7:0]                      answer;
        logic [FRAME_BYTES_MAX-1:0][7:0] frame;
    } cmd_t;

endpackage

FILE: rtl/core/sensor_chain_frame_forwarder.sv
// Top level of the sensor chain frame forwarder: configuration registers,
// front end, command queue and result sequencer. Depends on scff_pkg and all scff_* modules.
//
// The block takes one input item per clock cycle while its command queue has room and hands
// out one result item per cycle from a registered output while m_ready is high. An instance
// answer causes one result item, slot and stop two, a tick packet three and a forwarded frame
// FRAME_BYTES or FRAME_BYTES + 1, all sent through the single output register of the sequencer.
// The instance table is a RAM read as the item enters and written as the item leaves the input
// register; clearing it on a start byte or a tick packet takes effect at once through per-entry
// valid flags, so there is no clearing pass after reset. Configuration writes are taken in any
// cycle and must only be made while the block is idle.
module sensor_chain_frame_forwarder #(
    parameter int OBS_ENTRIES    = scff_pkg::OBS_ENTRIES_DEF,
    parameter int INSTANCE_LIMIT = scff_pkg::INSTANCE_LIMIT_DEF,
    parameter int FRAME_BYTES    = scff_pkg::FRAME_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scff_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  scff_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output scff_pkg::out_item_t               m_data
);

    scff_pkg::cfg_t cfg_reg, cfg_next;
    logic           q_push, q_full, q_pop, q_valid;
    scff_pkg::cmd_t push_cmd, head_cmd;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                scff_pkg::CFG_START_CODE:   cfg_next.start_code   = cfg_wdata;
                scff_pkg::CFG_STOP_CODE:    cfg_next.stop_code    = cfg_wdata;
                scff_pkg::CFG_SILENT_TICKS: cfg_next.silent_ticks = cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_code   <= scff_pkg::START_CODE_RST;
            cfg_reg.stop_code    <= scff_pkg::STOP_CODE_RST;
            cfg_reg.silent_ticks <= scff_pkg::SILENT_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    scff_front #(
        .OBS_ENTRIES    (OBS_ENTRIES),
        .INSTANCE_LIMIT (INSTANCE_LIMIT),
        .FRAME_BYTES    (FRAME_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .push     (q_push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    scff_queue #(
        .DEPTH (scff_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head_cmd),
        .q_valid  (q_valid)
    );

    scff_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_cmd   (head_cmd),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("Command pushed into a full queue.");

    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> q_valid)
        else $error("Command popped from an empty queue.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.out_kind != scff_pkg::OUT_BYTE)) |->
        ((m_data.out_byte == 8'd0)
         && ((m_data.out_kind == scff_pkg::OUT_ANSWER) || (m_data.next_instance == 8'd0))))
        else $error("Result carries a byte or instance that does not belong to its kind.");

endmodule

FILE: rtl/core/scff_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module scff_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/scff_front.sv
// Front end: accepts input items, runs the packet scanner and the instance table.
// Depends on scff_pkg and scff_ram; emits one command per item that has results.
module scff_front #(
    parameter int OBS_ENTRIES    = scff_pkg::OBS_ENTRIES_DEF,
    parameter int INSTANCE_LIMIT = scff_pkg::INSTANCE_LIMIT_DEF,
    parameter int FRAME_BYTES    = scff_pkg::FRAME_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  scff_pkg::cfg_t     cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  scff_pkg::in_item_t s_data,
    output logic               push,
    output scff_pkg::cmd_t     push_cmd,
    input  logic               q_full
);

    localparam int AW = (OBS_ENTRIES > 1) ? $clog2(OBS_ENTRIES) : 1;
    localparam int CW = $clog2(FRAME_BYTES);
    localparam logic [CW-1:0] LAST_IDX = CW'(FRAME_BYTES - 1);
    localparam logic [7:0] INST_LIMIT = 8'(INSTANCE_LIMIT);
    localparam logic [scff_pkg::ADDR_W:0] OBS_LIMIT = (scff_pkg::ADDR_W + 1)'(OBS_ENTRIES);

    typedef enum logic [4:0] {
        ST_SCAN       = 5'b00001,
        ST_START      = 5'b00010,
        ST_START_BAD  = 5'b00100,
        ST_PACKET     = 5'b01000,
        ST_PACKET_BAD = 5'b10000
    } scan_state_t;

    logic                ex_valid_reg, ex_valid_next;
    scff_pkg::in_item_t  ex_item_reg;
    scan_state_t         state_reg, state_next, st_bad;
    logic [CW-1:0]       count_reg, count_next;
    logic [3:0]          quiet_reg, quiet_next;
    logic [7:0]          fb_reg [FRAME_BYTES];
    logic [7:0]          fb_next [FRAME_BYTES];
    logic [7:0]          frame_now [FRAME_BYTES];
    logic [OBS_ENTRIES-1:0] tbl_valid_reg, tbl_valid_next;
    logic                rd_valid_reg, rd_byp_reg;
    logic [7:0]          rd_byp_data_reg;

    logic                fire, accept, running;
    logic [7:0]          rx_byte, inst, table_val, ram_q;
    logic [scff_pkg::ADDR_W-1:0] frame_addr, req_addr, rd_addr12;
    logic [AW-1:0]       raddr, tbl_waddr;
    logic [7:0]          tbl_wdata;
    logic                tbl_we, tbl_clear, frame_sane, req_in_range;

    assign fire    = ex_valid_reg && !q_full;
    assign s_ready = !ex_valid_reg || !q_full;
    assign accept  = s_valid && s_ready;
    assign running = (state_reg != ST_SCAN);
    assign rx_byte = ex_item_reg.rx_byte;
    assign req_addr = ex_item_reg.obs_address;

    always_comb begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_now[i] = (CW'(i) == count_reg) ? rx_byte : fb_reg[i];
        end
    end

    assign frame_addr = {frame_now[0][5:0], frame_now[1][5:0]};
    assign inst       = frame_now[2];
    assign table_val  = rd_byp_reg ? rd_byp_data_reg : (rd_valid_reg ? ram_q : 8'd0);
    assign frame_sane = ({1'b0, frame_addr} < OBS_LIMIT) && (inst < INST_LIMIT)
                        && (table_val <= inst);
    assign req_in_range = ({1'b0, req_addr} < OBS_LIMIT);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        quiet_next     = quiet_reg;
        fb_next        = fb_reg;
        st_bad         = state_reg;
        tbl_we         = 1'b0;
        tbl_clear      = 1'b0;
        tbl_waddr      = frame_addr[AW-1:0];
        tbl_wdata      = inst + 8'd1;
        push           = 1'b0;
        push_cmd.op    = scff_pkg::CMD_ANSWER;
        push_cmd.answer = 8'd0;
        push_cmd.frame = '0;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            push_cmd.frame[i] = frame_now[i];
        end
        if (fire) begin
            unique case (ex_item_reg.kind)
                scff_pkg::IN_BYTE: begin
                    if (rx_byte == cfg.start_code) begin
                        quiet_next = 4'd0;
                        state_next = ST_START;
                        count_next = '0;
                        tbl_clear  = 1'b1;
                    end else if (rx_byte == cfg.stop_code) begin
                        state_next = ST_SCAN;
                        if (running) begin
                            push        = 1'b1;
                            push_cmd.op = scff_pkg::CMD_SLOT_STOP;
                        end
                    end else if (running) begin
                        fb_next[count_reg] = rx_byte;
                        if (rx_byte > cfg.stop_code) begin
                            st_bad = (state_reg == ST_START) ? ST_START_BAD : ST_PACKET_BAD;
                        end
                        state_next = st_bad;
                        if (count_reg == LAST_IDX) begin
                            count_next = '0;
                            if (frame_sane) begin
                                tbl_we = 1'b1;
                                unique case (st_bad)
                                    ST_START: begin
                                        push        = 1'b1;
                                        push_cmd.op = scff_pkg::CMD_FRAME_START;
                                        state_next  = ST_PACKET;
                                    end
                                    ST_PACKET: begin
                                        push        = 1'b1;
                                        push_cmd.op = scff_pkg::CMD_FRAME;
                                    end
                                    ST_START_BAD:  state_next = ST_START;
                                    ST_PACKET_BAD: state_next = ST_PACKET;
                                    default:       state_next = st_bad;
                                endcase
                            end
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                scff_pkg::IN_TICK: begin
                    if (quiet_reg < cfg.silent_ticks) begin
                        quiet_next = quiet_reg + 4'd1;
                    end else begin
                        push        = 1'b1;
                        push_cmd.op = scff_pkg::CMD_TICK;
                        tbl_clear   = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
                scff_pkg::IN_REQUEST: begin
                    push        = 1'b1;
                    push_cmd.op = scff_pkg::CMD_ANSWER;
                    if (req_in_range) begin
                        push_cmd.answer = table_val;
                        tbl_we          = 1'b1;
                        tbl_waddr       = req_addr[AW-1:0];
                        tbl_wdata       = table_val + 8'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        tbl_valid_next = tbl_valid_reg;
        if (tbl_clear) begin
            tbl_valid_next = '0;
        end
        if (tbl_we) begin
            tbl_valid_next[tbl_waddr] = 1'b1;
        end
    end

    // The table read for an item is issued as it enters, against the state
    // that the item ahead of it leaves behind; a write in that same cycle is bypassed.
    assign rd_addr12 = (s_data.kind == scff_pkg::IN_REQUEST) ? s_data.obs_address
                                                              : {fb_next[0][5:0], fb_next[1][5:0]};
    assign raddr = rd_addr12[AW-1:0];

    assign ex_valid_next = accept ? 1'b1 : (fire ? 1'b0 : ex_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg  <= 1'b0;
            state_reg     <= ST_SCAN;
            count_reg     <= '0;
            quiet_reg     <= 4'd0;
            tbl_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            rd_byp_reg    <= 1'b0;
        end else begin
            ex_valid_reg  <= ex_valid_next;
            state_reg     <= state_next;
            count_reg     <= count_next;
            quiet_reg     <= quiet_next;
            tbl_valid_reg <= tbl_valid_next;
            if (accept) begin
                rd_valid_reg <= tbl_valid_next[raddr];
                rd_byp_reg   <= tbl_we && (tbl_waddr == raddr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        fb_reg <= fb_next;
        if (accept) begin
            ex_item_reg     <= s_data;
            rd_byp_data_reg <= tbl_wdata;
        end
    end

    scff_ram #(
        .WIDTH (8),
        .DEPTH (OBS_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (accept),
        .raddr (raddr),
        .rdata (ram_q)
    );

endmodule

FILE: rtl/core/scff_queue.sv
// Short command queue between the front end and the result sequencer.
// Depends on scff_pkg for the command type.
module scff_queue #(
    parameter int DEPTH = scff_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  scff_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output scff_pkg::cmd_t head,
    output logic           q_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [NW-1:0] DEPTH_N = NW'(DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    scff_pkg::cmd_t  slots [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg, count_next;

    assign full    = (count_reg == DEPTH_N);
    assign q_valid = (count_reg != '0);
    assign head    = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/core/scff_back.sv
// Result sequencer: expands queued commands into result items, one per cycle while m_ready allows.
// Depends on scff_pkg; drives the registered result channel.
module scff_back #(
    parameter int FRAME_BYTES = scff_pkg::FRAME_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  scff_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  scff_pkg::cmd_t      q_cmd,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output scff_pkg::out_item_t m_data
);

    localparam int SW = $clog2(FRAME_BYTES + 1);
    localparam logic [SW-1:0] FRAME_LAST = SW'(FRAME_BYTES - 1);
    localparam logic [SW-1:0] FRAME_START_LAST = SW'(FRAME_BYTES);

    scff_pkg::cmd_t      cur_reg;
    logic                busy_reg, busy_next;
    logic [SW-1:0]       step_reg, step_next, last_step;
    logic                m_valid_reg;
    scff_pkg::out_item_t m_data_reg, res;
    logic                out_load, emit, is_last;
    logic [scff_pkg::FRAME_IDX_W-1:0] byte_idx;

    assign out_load = !m_valid_reg || m_ready;
    assign emit     = busy_reg && out_load;
    assign is_last  = (step_reg == last_step);
    assign pop      = q_valid && (!busy_reg || (emit && is_last));

    always_comb begin
        res       = '0;
        last_step = '0;
        byte_idx  = scff_pkg::FRAME_IDX_W'(step_reg);
        unique case (cur_reg.op)
            scff_pkg::CMD_FRAME: begin
                last_step    = FRAME_LAST;
                res.out_kind = scff_pkg::OUT_BYTE;
                res.out_byte = cur_reg.frame[byte_idx];
            end
            scff_pkg::CMD_FRAME_START: begin
                last_step    = FRAME_START_LAST;
                byte_idx     = scff_pkg::FRAME_IDX_W'(step_reg - 1'b1);
                res.out_kind = scff_pkg::OUT_BYTE;
                res.out_byte = (step_reg == '0) ? cfg.start_code : cur_reg.frame[byte_idx];
            end
            scff_pkg::CMD_SLOT_STOP: begin
                last_step = SW'(1);
                if (step_reg == '0) begin
                    res.out_kind = scff_pkg::OUT_SLOT;
                end else begin
                    res.out_kind = scff_pkg::OUT_BYTE;
                    res.out_byte = cfg.stop_code;
                end
            end
            scff_pkg::CMD_TICK: begin
                last_step = SW'(2);
                if (step_reg == '0) begin
                    res.out_kind = scff_pkg::OUT_BYTE;
                    res.out_byte = cfg.start_code;
                end else if (step_reg == SW'(1)) begin
                    res.out_kind = scff_pkg::OUT_SLOT;
                end else begin
                    res.out_kind = scff_pkg::OUT_BYTE;
                    res.out_byte = cfg.stop_code;
                end
            end
            scff_pkg::CMD_ANSWER: begin
                res.out_kind      = scff_pkg::OUT_ANSWER;
                res.next_instance = cur_reg.answer;
            end
            default: begin
            end
        endcase
        res.last = is_last;
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (pop) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (emit) begin
            if (is_last) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= q_cmd;
        end
        if (emit) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
